[src/tagged_network_name_parser_macros.svh]
// ----------------------------------------------------------------------------
// Tagged network name parser assertion macros
// Shorthand for the clocked assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef TAGGED_NETWORK_NAME_PARSER_MACROS_SVH
`define TAGGED_NETWORK_NAME_PARSER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TNNP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TNNP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/tnnp_pkg.sv]
// ----------------------------------------------------------------------------
// tnnp_pkg
// Shared types and constants of the tagged network name parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tnnp_pkg;

   localparam int MAX_CODE_CHARS = 12;
   localparam int MIN_CODE_CHARS = 8;
   localparam int CODE_SLOTS     = 12;
   localparam int CNT_W          = $clog2(MAX_CODE_CHARS + 1);
   localparam int LEN_W          = 4;

   // Parse phases
   localparam logic [2:0] PH_NAME   = 3'd0;
   localparam logic [2:0] PH_CODE   = 3'd1;
   localparam logic [2:0] PH_STATUS = 3'd2;
   localparam logic [2:0] PH_DOT    = 3'd3;
   localparam logic [2:0] PH_TYPE   = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   // Letter indexes; LETTER_NONE marks a byte outside the five-letter set
   localparam logic [2:0] LETTER_DEFAULT = 3'd2;
   localparam logic [2:0] LETTER_MAX     = 3'd4;
   localparam logic [2:0] LETTER_NONE    = 3'd5;

   localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
   localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]
   localparam logic [7:0] CH_DOT   = 8'h2E;  // .
   localparam logic [7:0] CH_DASH  = 8'd45;
   localparam logic [7:0] CH_UNDER = 8'd95;
   localparam logic [7:0] CH_SPACE = 8'd32;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic             matched;
      logic [2:0]       status_letter;
      logic [2:0]       type_letter;
      logic [LEN_W-1:0] code_length;
      logic [63:0]      code_first_eight;
      logic [31:0]      code_last_four;
   } rsp_type;

   // Character classes of one byte
   typedef struct packed {
      logic       alnum;
      logic       name_ok;
      logic       open_br;
      logic       close_br;
      logic       dot;
      logic [2:0] status_idx;
      logic [2:0] type_idx;
   } class_type;

endpackage

`default_nettype wire

[src/tagged_network_name_parser.sv]
// A result is registered when the request carrying the last byte is accepted and appears in the next cycle.
// The parser takes one request per cycle while req_ready is high; each accepted byte advances the parse state.
// The result register stalls intake only when it is full and not being taken.
// Reset (synchronous, active high) returns the parser to the name phase.
// ----------------------------------------------------------------------------
// tagged_network_name_parser
// Checks names of the form name[code]s.t byte by byte and reports the match.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_network_name_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tnnp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tnnp_pkg::rsp_type rsp_data
);
   import tnnp_pkg::*;

   // Parse state
   logic [2:0]       phase_ff, phase_in;
   logic             rej_ff, rej_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       code_ff [CODE_SLOTS];
   logic [7:0]       code_in [CODE_SLOTS];
   logic [2:0]       status_ff, status_in;
   logic [2:0]       type_ff, type_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // Next state before end-of-name restart
   logic [2:0]       phase_nx;
   logic             rej_nx;
   logic [CNT_W-1:0] cnt_nx;
   logic [7:0]       code_nx [CODE_SLOTS];
   logic [2:0]       status_nx, type_nx;
   logic             ok;

   class_type        cls;
   logic             accept;

   tnnp_classify u_classify (
      .ch  (req_data.ch),
      .cls (cls)
   );

   // Take a new byte whenever the result slot is free or draining this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Advance the parse by one byte
   always_comb begin
      phase_nx  = phase_ff;
      rej_nx    = rej_ff;
      cnt_nx    = cnt_ff;
      status_nx = status_ff;
      type_nx   = type_ff;
      for (int i = 0; i < CODE_SLOTS; i++) begin
         code_nx[i] = code_ff[i];
      end

      // A rejected name ignores everything until its last byte
      if (!rej_ff) begin
         unique case (phase_ff)
            PH_NAME: begin
               if (!cls.name_ok) begin
                  if (cls.open_br) phase_nx = PH_CODE;
                  else             rej_nx   = 1'b1;
               end
            end
            PH_CODE: begin
               if (cls.close_br) begin
                  phase_nx = PH_STATUS;
               end else if (!cls.alnum || (cnt_ff >= CNT_W'(MAX_CODE_CHARS))) begin
                  rej_nx = 1'b1;
               end else begin
                  // Store into the slot the count points at and advance the count
                  for (int i = 0; i < CODE_SLOTS; i++) begin
                     if (cnt_ff == CNT_W'(i)) code_nx[i] = req_data.ch;
                  end
                  cnt_nx = cnt_ff + CNT_W'(1);
               end
            end
            PH_STATUS: begin
               if (cls.status_idx > LETTER_MAX) begin
                  rej_nx = 1'b1;
               end else begin
                  status_nx = cls.status_idx;
                  phase_nx  = PH_DOT;
               end
            end
            PH_DOT: begin
               if (cls.dot) phase_nx = PH_TYPE;
               else         rej_nx   = 1'b1;
            end
            PH_TYPE: begin
               if (cls.type_idx > LETTER_MAX) begin
                  rej_nx = 1'b1;
               end else begin
                  type_nx  = cls.type_idx;
                  phase_nx = PH_DONE;
               end
            end
            default: rej_nx = 1'b1;  // trailing byte after the type letter
         endcase
      end
   end

   // Build the result from the updated state
   always_comb begin
      ok = !rej_nx && (phase_nx == PH_DONE) &&
           (cnt_nx >= CNT_W'(MIN_CODE_CHARS)) && (cnt_nx <= CNT_W'(MAX_CODE_CHARS));

      rsp_in                  = '0;
      rsp_in.matched          = ok;
      rsp_in.status_letter    = ok ? status_nx : LETTER_DEFAULT;
      rsp_in.type_letter      = ok ? type_nx : LETTER_DEFAULT;
      rsp_in.code_length      = ok ? LEN_W'(cnt_nx) : '0;
      if (ok) begin
         for (int i = 0; i < 8; i++) begin
            rsp_in.code_first_eight[8*i +: 8] = code_nx[i];
         end
         for (int i = 0; i < 4; i++) begin
            rsp_in.code_last_four[8*i +: 8] = code_nx[8 + i];
         end
      end
   end

   // Commit the byte; the last byte restarts the parser for the next name
   always_comb begin
      phase_in     = phase_ff;
      rej_in       = rej_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      type_in      = type_ff;
      for (int i = 0; i < CODE_SLOTS; i++) begin
         code_in[i] = code_ff[i];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         if (req_data.last) begin
            phase_in     = PH_NAME;
            rej_in       = 1'b0;
            cnt_in       = '0;
            status_in    = LETTER_DEFAULT;
            type_in      = LETTER_DEFAULT;
            for (int i = 0; i < CODE_SLOTS; i++) begin
               code_in[i] = '0;
            end
            rsp_valid_in = 1'b1;
         end else begin
            phase_in  = phase_nx;
            rej_in    = rej_nx;
            cnt_in    = cnt_nx;
            status_in = status_nx;
            type_in   = type_nx;
            for (int i = 0; i < CODE_SLOTS; i++) begin
               code_in[i] = code_nx[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NAME;
         rej_ff       <= 1'b0;
         cnt_ff       <= '0;
         status_ff    <= LETTER_DEFAULT;
         type_ff      <= LETTER_DEFAULT;
         for (int i = 0; i < CODE_SLOTS; i++) begin
            code_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rej_ff       <= rej_in;
         cnt_ff       <= cnt_in;
         status_ff    <= status_in;
         type_ff      <= type_in;
         for (int i = 0; i < CODE_SLOTS; i++) begin
            code_ff[i] <= code_in[i];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload until it is taken
   always_ff @(posedge clock) begin
      if (accept && req_data.last) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

[src/tnnp_classify.sv]
// ----------------------------------------------------------------------------
// tnnp_classify
// Sorts one byte into the character classes the parser needs.
// ----------------------------------------------------------------------------
`default_nettype none

module tnnp_classify (
   input  logic [7:0]          ch,
   output tnnp_pkg::class_type cls
);
   import tnnp_pkg::*;

   logic upper, lower, digit;

   assign upper = (ch >= 8'd65) && (ch <= 8'd90);
   assign lower = (ch >= 8'd97) && (ch <= 8'd122);
   assign digit = (ch >= 8'd48) && (ch <= 8'd57);

   always_comb begin
      cls.alnum    = upper || lower || digit;
      cls.name_ok  = upper || lower || digit ||
                     (ch == CH_DASH) || (ch == CH_UNDER) || (ch == CH_SPACE);
      cls.open_br  = (ch == CH_OPEN);
      cls.close_br = (ch == CH_CLOSE);
      cls.dot      = (ch == CH_DOT);

      case (ch)
         8'h77:   cls.status_idx = 3'd0;  // w
         8'h63:   cls.status_idx = 3'd1;  // c
         8'h78:   cls.status_idx = 3'd2;  // x
         8'h79:   cls.status_idx = 3'd3;  // y
         8'h7A:   cls.status_idx = 3'd4;  // z
         default: cls.status_idx = LETTER_NONE;
      endcase

      case (ch)
         8'h61:   cls.type_idx = 3'd0;  // a
         8'h65:   cls.type_idx = 3'd1;  // e
         8'h69:   cls.type_idx = 3'd2;  // i
         8'h6F:   cls.type_idx = 3'd3;  // o
         8'h75:   cls.type_idx = 3'd4;  // u
         default: cls.type_idx = LETTER_NONE;
      endcase
   end

endmodule

`default_nettype wire

[src/tnnp_checker.sv]
// ----------------------------------------------------------------------------
// tnnp_port_checker
// Port-level checks of the tagged network name parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tagged_network_name_parser_macros.svh"

module tnnp_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tnnp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tnnp_pkg::rsp_type rsp_data
);
   import tnnp_pkg::*;

   logic mid_accept;
   logic miss_clear;
   logic match_range;

   // A request that does not end a name
   assign mid_accept = req_valid && req_ready && !req_data.last;

   // An unmatched result carries only the default fields
   assign miss_clear = (rsp_data.status_letter == LETTER_DEFAULT) &&
                       (rsp_data.type_letter == LETTER_DEFAULT) &&
                       (rsp_data.code_length == '0) &&
                       (rsp_data.code_first_eight == '0) &&
                       (rsp_data.code_last_four == '0);

   assign match_range = (rsp_data.code_length >= LEN_W'(MIN_CODE_CHARS)) &&
                        (rsp_data.status_letter <= LETTER_MAX) &&
                        (rsp_data.type_letter <= LETTER_MAX);

   `TNNP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result pending after reset")

   `TNNP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "stalled result dropped")

   `TNNP_ASSERT(a_no_spurious, mid_accept && !rsp_valid |=> !rsp_valid, "result without last byte")

   `TNNP_ASSERT(a_miss_defaults, rsp_valid && !rsp_data.matched |-> miss_clear, "unmatched result not cleared")

   `TNNP_ASSERT(a_match_range, rsp_valid && rsp_data.matched |-> match_range, "matched result out of range")

endmodule

bind tagged_network_name_parser tnnp_port_checker u_tnnp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
